/* src/mandel_pkg.sv */
// shared constants, types and helper functions for the escape-time pixel block
// no dependencies; imported by mandel_div, mandelbrot_escape_time_pixel and tb_top
`default_nettype none

package mandel_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int MAX_DIM    = 4096;
    localparam int DIM_BITS   = $clog2(MAX_DIM) + 1;
    localparam int POS_BITS   = 12;
    localparam int COUNT_BITS = 8;
    localparam int IDX_BITS   = 3;

    // magnitude of span times position, and the signed quotient
    localparam int MAG_BITS   = COORD_BITS + POS_BITS;
    localparam int QUOT_BITS  = MAG_BITS + 1;
    localparam int WIDE_BITS  = MAG_BITS + 4;
    localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

    // shared multiplier operands and scaled products
    localparam int OP_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * OP_BITS;
    localparam int SQ_BITS    = 2 * COORD_BITS - FRAC_BITS;
    localparam int XP_BITS    = SQ_BITS + 1;

    typedef logic [IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_X_START  = 3'd0;
    localparam cfg_idx_t REG_Y_START  = 3'd1;
    localparam cfg_idx_t REG_X_END    = 3'd2;
    localparam cfg_idx_t REG_Y_END    = 3'd3;
    localparam cfg_idx_t REG_WIDTH    = 3'd4;
    localparam cfg_idx_t REG_HEIGHT   = 3'd5;
    localparam cfg_idx_t REG_LIMIT    = 3'd6;

    localparam logic signed [COORD_BITS-1:0] X_START_RST = 32'shE000_0000;
    localparam logic signed [COORD_BITS-1:0] Y_START_RST = 32'shE800_0000;
    localparam logic signed [COORD_BITS-1:0] X_END_RST   = 32'sh1000_0000;
    localparam logic signed [COORD_BITS-1:0] Y_END_RST   = 32'sh1800_0000;
    localparam logic [DIM_BITS-1:0]          DIM_RST     = 13'd1024;
    localparam logic [COUNT_BITS-1:0]        LIMIT_RST   = 8'd255;

    // escape threshold, 4.0 in the squared-magnitude scale
    localparam logic [SQ_BITS:0] ESC_LIMIT = (SQ_BITS + 1)'(4) << FRAC_BITS;

    localparam logic signed [WIDE_BITS-1:0] COORD_MAX_W =
        {{(WIDE_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [WIDE_BITS-1:0] COORD_MIN_W =
        {{(WIDE_BITS - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD_RE,
        S_DIV_RE,
        S_PROD_IM,
        S_DIV_IM,
        S_MUL_RR,
        S_MUL_II,
        S_MUL_RI,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
        if (d == '0)
            clamp_dim = DIM_BITS'(1);
        else if (d > DIM_BITS'(MAX_DIM))
            clamp_dim = DIM_BITS'(MAX_DIM);
        else
            clamp_dim = d;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_BITS-1:0] v
    );
        if (v > COORD_MAX_W)
            sat_coord = COORD_MAX_W[COORD_BITS-1:0];
        else if (v < COORD_MIN_W)
            sat_coord = COORD_MIN_W[COORD_BITS-1:0];
        else
            sat_coord = v[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/mandel_div.sv */
// restoring divider, one quotient bit per cycle, result truncated toward zero
// depends on mandel_pkg for widths and the status struct
`default_nettype none

module mandel_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   neg,
    input  logic [mandel_pkg::MAG_BITS-1:0]        dividend,
    input  logic [mandel_pkg::DIM_BITS-1:0]        divisor,
    output logic signed [mandel_pkg::QUOT_BITS-1:0] quot,
    output mandel_pkg::div_stat_t                  stat
);
    import mandel_pkg::*;

    logic [MAG_BITS-1:0]        quo_reg, quo_next;
    logic [DIM_BITS-1:0]        rem_reg, rem_next;
    logic [DIM_BITS-1:0]        dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic signed [QUOT_BITS-1:0] quot_reg, quot_next;

    logic [DIM_BITS:0]   partial;
    logic [DIM_BITS:0]   diff;
    logic                ge;
    logic [MAG_BITS-1:0] quo_shift;
    logic [QUOT_BITS-1:0] quo_ext;

    assign partial   = {rem_reg, quo_reg[MAG_BITS-1]};
    assign ge        = partial >= {1'b0, dsr_reg};
    assign diff      = partial - {1'b0, dsr_reg};
    assign quo_shift = {quo_reg[MAG_BITS-2:0], ge};
    assign quo_ext   = {1'b0, quo_shift};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = neg;
            cnt_next  = CNT_BITS'(MAG_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = quo_shift;
            rem_next = ge ? diff[DIM_BITS-1:0] : partial[DIM_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* src/mandelbrot_escape_time_pixel.sv */
// escape-time evaluator for one pixel: window mapping, then z = z*z + c iteration
// depends on mandel_pkg and mandel_div
// coordinate mapping: two 44-step divisions on the shared divider, then each iteration
// forms the squares and the cross product on the shared 33x33 multiplier and updates z;
// the count goes to the output beat register; a new pixel is taken only when idle
// reset: window -2.0..1.0 by -1.5..1.5, 1024 x 1024 pixels, limit 255; block idle
`default_nettype none

module mandelbrot_escape_time_pixel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [11:0]                         pixel_column,
    input  logic [11:0]                         pixel_row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          escape_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mandel_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);
    import mandel_pkg::*;

    state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] x_start_reg, x_start_next;
    logic signed [COORD_BITS-1:0] y_start_reg, y_start_next;
    logic signed [COORD_BITS-1:0] x_end_reg, x_end_next;
    logic signed [COORD_BITS-1:0] y_end_reg, y_end_next;
    logic [DIM_BITS-1:0]          width_reg, width_next;
    logic [DIM_BITS-1:0]          height_reg, height_next;
    logic [COUNT_BITS-1:0]        limit_cfg_reg, limit_cfg_next;

    logic [POS_BITS-1:0]          col_reg, col_next;
    logic [POS_BITS-1:0]          row_reg, row_next;
    logic [COUNT_BITS-1:0]        limit_reg, limit_next;
    logic [MAG_BITS-1:0]          mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic signed [COORD_BITS-1:0] cr_reg, cr_next;
    logic signed [COORD_BITS-1:0] ci_reg, ci_next;
    logic signed [COORD_BITS-1:0] zr_reg, zr_next;
    logic signed [COORD_BITS-1:0] zi_reg, zi_next;
    logic signed [SQ_BITS-1:0]    r2_reg, r2_next;
    logic signed [SQ_BITS-1:0]    i2_reg, i2_next;
    logic signed [XP_BITS-1:0]    xp_reg, xp_next;
    logic [COUNT_BITS-1:0]        iter_reg, iter_next;
    logic                         out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]        count_out_reg, count_out_next;

    logic                          in_accept;
    logic                          div_start;
    logic                          out_load;
    logic signed [OP_BITS-1:0]     op_a, op_b;
    logic signed [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-1:0]          prod_neg;
    logic [DIM_BITS-1:0]           div_dim;
    logic signed [QUOT_BITS-1:0]   quot;
    div_stat_t                     div_stat;
    logic signed [COORD_BITS-1:0]  map_base;
    logic signed [COORD_BITS-1:0]  coord_map;
    logic [SQ_BITS:0]              sq_sum;
    logic                          escaped;
    logic                          iter_last;
    logic signed [WIDE_BITS-1:0]   zr_sum, zi_sum;

    // shared multiplier
    assign prod     = op_a * op_b;
    assign prod_neg = -prod;

    assign div_dim = clamp_dim((state_reg == S_DIV_RE) ? width_reg : height_reg);

    mandel_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (neg_reg),
        .dividend (mag_reg),
        .divisor  (div_dim),
        .quot     (quot),
        .stat     (div_stat)
    );

    assign map_base  = (state_reg == S_DIV_RE) ? x_start_reg : y_start_reg;
    assign coord_map = sat_coord(WIDE_BITS'(map_base) + WIDE_BITS'(quot));

    assign sq_sum    = {1'b0, r2_reg} + {1'b0, i2_reg};
    assign escaped   = sq_sum > ESC_LIMIT;
    assign iter_last = (iter_reg + COUNT_BITS'(1)) == limit_reg;
    assign zi_sum    = WIDE_BITS'(xp_reg) + WIDE_BITS'(ci_reg);
    assign zr_sum    = WIDE_BITS'(r2_reg) - WIDE_BITS'(i2_reg) + WIDE_BITS'(cr_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_PROD_RE;
            S_PROD_RE: state_next = S_DIV_RE;
            S_DIV_RE:  if (div_stat.done) state_next = S_PROD_IM;
            S_PROD_IM: state_next = S_DIV_IM;
            S_DIV_IM:  if (div_stat.done) state_next = S_MUL_RR;
            S_MUL_RR:  state_next = S_MUL_II;
            S_MUL_II:  state_next = S_MUL_RI;
            S_MUL_RI:  state_next = escaped ? S_DONE : S_UPDATE;
            S_UPDATE:  state_next = iter_last ? S_DONE : S_MUL_RR;
            S_DONE:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        op_a      = {zr_reg[COORD_BITS-1], zr_reg};
        op_b      = {zi_reg[COORD_BITS-1], zi_reg};
        unique case (state_reg)
            S_IDLE:
                in_ready = 1'b1;
            S_PROD_RE:
            begin
                op_a = {x_end_reg[COORD_BITS-1], x_end_reg}
                     - {x_start_reg[COORD_BITS-1], x_start_reg};
                op_b = OP_BITS'(col_reg);
            end
            S_PROD_IM:
            begin
                op_a = {y_end_reg[COORD_BITS-1], y_end_reg}
                     - {y_start_reg[COORD_BITS-1], y_start_reg};
                op_b = OP_BITS'(row_reg);
            end
            S_DIV_RE, S_DIV_IM:
                div_start = !div_stat.busy && !div_stat.done;
            S_MUL_RR:
                op_b = {zr_reg[COORD_BITS-1], zr_reg};
            S_MUL_II:
                op_a = {zi_reg[COORD_BITS-1], zi_reg};
            S_MUL_RI, S_UPDATE:
                ;
            S_DONE:
                out_load = !out_valid_reg || out_ready;
            default:
                ;
        endcase
    end

    assign in_accept = in_valid && in_ready;

    // datapath
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        limit_next     = limit_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        r2_next        = r2_reg;
        i2_next        = i2_reg;
        xp_next        = xp_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        count_out_next = count_out_reg;

        if (in_accept)
        begin
            col_next   = pixel_column;
            row_next   = pixel_row;
            limit_next = (limit_cfg_reg == '0) ? COUNT_BITS'(1) : limit_cfg_reg;
        end
        if (state_reg == S_PROD_RE || state_reg == S_PROD_IM)
        begin
            neg_next = prod[PROD_BITS-1];
            mag_next = prod[PROD_BITS-1] ? prod_neg[MAG_BITS-1:0] : prod[MAG_BITS-1:0];
        end
        if (state_reg == S_DIV_RE && div_stat.done)
            cr_next = coord_map;
        if (state_reg == S_DIV_IM && div_stat.done)
        begin
            ci_next   = coord_map;
            zr_next   = cr_reg;
            zi_next   = coord_map;
            iter_next = '0;
        end
        if (state_reg == S_MUL_RR)
            r2_next = prod[2*COORD_BITS-1:FRAC_BITS];
        if (state_reg == S_MUL_II)
            i2_next = prod[2*COORD_BITS-1:FRAC_BITS];
        if (state_reg == S_MUL_RI)
            xp_next = prod[2*COORD_BITS-1:FRAC_BITS-1];
        if (state_reg == S_UPDATE)
        begin
            zr_next   = sat_coord(zr_sum);
            zi_next   = sat_coord(zi_sum);
            iter_next = iter_reg + COUNT_BITS'(1);
        end

        // output beat register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            count_out_next = iter_reg;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        x_start_next   = x_start_reg;
        y_start_next   = y_start_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        limit_cfg_next = limit_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_START: x_start_next   = cfg_data;
                REG_Y_START: y_start_next   = cfg_data;
                REG_X_END:   x_end_next     = cfg_data;
                REG_Y_END:   y_end_next     = cfg_data;
                REG_WIDTH:   width_next     = cfg_data[DIM_BITS-1:0];
                REG_HEIGHT:  height_next    = cfg_data[DIM_BITS-1:0];
                REG_LIMIT:   limit_cfg_next = cfg_data[COUNT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            x_start_reg   <= X_START_RST;
            y_start_reg   <= Y_START_RST;
            x_end_reg     <= X_END_RST;
            y_end_reg     <= Y_END_RST;
            width_reg     <= DIM_RST;
            height_reg    <= DIM_RST;
            limit_cfg_reg <= LIMIT_RST;
            limit_reg     <= LIMIT_RST;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            x_start_reg   <= x_start_next;
            y_start_reg   <= y_start_next;
            x_end_reg     <= x_end_next;
            y_end_reg     <= y_end_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            limit_cfg_reg <= limit_cfg_next;
            limit_reg     <= limit_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        r2_reg        <= r2_next;
        i2_reg        <= i2_next;
        xp_reg        <= xp_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = count_out_reg;

    // checks
    a_div_done_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV_RE || state_reg == S_DIV_IM))
        else $error("divider finished outside coordinate mapping");

    a_iter_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_RR) |-> (iter_reg < limit_reg))
        else $error("iteration count reached limit while still iterating");

    a_done_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (iter_reg <= limit_reg))
        else $error("escape count beyond iteration limit");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output beat still pending");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// testbench for mandelbrot_escape_time_pixel: directed tests, then random windows and pixels
// expected escape counts come from an in-bench fixed-point model; needs mandel_pkg and the rtl

module tb_top;
    import mandel_pkg::*;

    localparam int       WATCHDOG_CYCLES = 20000;
    localparam int       HOLD_CYCLES     = 3000;
    localparam int       SETTLE_CYCLES   = 1200;
    localparam int       ONE             = 1 << FRAC_BITS;
    localparam longint   COORD_HI        = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint   COORD_LO        = -COORD_HI - 1;
    localparam longint   ESCAPE_R2       = longint'(4) <<< FRAC_BITS;
    localparam cfg_idx_t REG_UNUSED      = 3'd7;

    typedef struct {
        logic signed [31:0] x_start;
        logic signed [31:0] y_start;
        logic signed [31:0] x_end;
        logic signed [31:0] y_end;
        logic [12:0]        width;
        logic [12:0]        height;
        logic [7:0]         iter_limit;
    } window_t;

    typedef struct {
        logic [7:0]  count;
        logic [11:0] col;
        logic [11:0] row;
    } escape_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  escape_count;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;

    window_t     window;
    escape_t     pending_counts[$];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_left;
    int          quiet_cycles;
    int          n_pixels;
    int          n_checked;
    int          n_cfg_writes;
    int          n_errors;

    mandelbrot_escape_time_pixel i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .escape_count (escape_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint dim_used(logic [12:0] d);
        if (d == 13'd0)
            return 1;
        if (d > 13'(MAX_DIM))
            return MAX_DIM;
        return longint'(d);
    endfunction

    function automatic longint clip_coord(longint v);
        if (v > COORD_HI)
            return COORD_HI;
        if (v < COORD_LO)
            return COORD_LO;
        return v;
    endfunction

    function automatic longint map_axis(logic signed [31:0] lo_edge, logic signed [31:0] hi_edge,
                                        logic [11:0] pos, logic [12:0] dim);
        longint span;
        span = longint'(hi_edge) - longint'(lo_edge);
        return clip_coord(longint'(lo_edge) + (span * longint'(pos)) / dim_used(dim));
    endfunction

    function automatic logic [7:0] escape_time(window_t w, logic [11:0] col, logic [11:0] row);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint rr;
        longint ii;
        longint ri;
        int     limit;
        cr    = map_axis(w.x_start, w.x_end, col, w.width);
        ci    = map_axis(w.y_start, w.y_end, row, w.height);
        limit = (w.iter_limit == 8'd0) ? 1 : int'(w.iter_limit);
        zr    = cr;
        zi    = ci;
        for (int n = 0; n < limit; n++)
        begin
            rr = (zr * zr) >>> FRAC_BITS;
            ii = (zi * zi) >>> FRAC_BITS;
            if (rr + ii > ESCAPE_R2)
                return 8'(n);
            ri = (zr * zi) >>> (FRAC_BITS - 1);
            zi = clip_coord(ri + ci);
            zr = clip_coord(rr - ii + cr);
        end
        return 8'(limit);
    endfunction

    function automatic logic [11:0] random_pos(logic [12:0] dim);
        if ($urandom_range(7) == 0)
            return 12'($urandom);
        return 12'($urandom_range(int'(dim_used(dim)) - 1, 0));
    endfunction

    function automatic logic [12:0] random_dim();
        case ($urandom_range(15))
            0:       return 13'd0;
            1:       return 13'($urandom_range(8191, MAX_DIM + 1));
            default: return 13'($urandom_range(MAX_DIM, 1));
        endcase
    endfunction

    // register shadow, expected counts, result checks and the receiver side
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            n_cfg_writes++;
            case (cfg_index)
                REG_X_START: window.x_start    = cfg_data;
                REG_Y_START: window.y_start    = cfg_data;
                REG_X_END:   window.x_end      = cfg_data;
                REG_Y_END:   window.y_end      = cfg_data;
                REG_WIDTH:   window.width      = cfg_data[12:0];
                REG_HEIGHT:  window.height     = cfg_data[12:0];
                REG_LIMIT:   window.iter_limit = cfg_data[7:0];
                default:     ;
            endcase
        end
        if (in_valid && in_ready)
        begin
            pending_counts.push_back(escape_t'{escape_time(window, pixel_column, pixel_row),
                                               pixel_column, pixel_row});
            n_pixels++;
        end
        if (out_valid && out_ready)
        begin
            n_checked++;
            if (pending_counts.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, got %0d",
                         $time, escape_count);
                n_errors++;
            end
            else
            begin
                if (escape_count !== pending_counts[0].count)
                begin
                    $display("%0t: pixel (%0d,%0d) escape count expected %0d, got %0d", $time,
                             pending_counts[0].col, pending_counts[0].row,
                             pending_counts[0].count, escape_count);
                    n_errors++;
                end
                void'(pending_counts.pop_front());
            end
        end
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pixel_column <= col;
        pixel_row    <= row;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_random_window();
        logic signed [31:0] xs;
        logic signed [31:0] xe;
        logic signed [31:0] ys;
        logic signed [31:0] ye;
        logic signed [31:0] t;
        logic [7:0]         lim;
        if ($urandom_range(9) == 0)
        begin
            xs = $urandom;
            xe = $urandom;
            ys = $urandom;
            ye = $urandom;
        end
        else
        begin
            // windows around the set, sometimes reversed
            xs = $urandom_range(ONE / 4 * 11, 0) - ONE / 2 * 5;
            xe = xs + $urandom_range(ONE * 3, ONE / 256);
            ys = $urandom_range(ONE / 2 * 5, 0) - ONE / 2 * 3;
            ye = ys + $urandom_range(ONE * 3, ONE / 256);
            if ($urandom_range(3) == 0)
            begin
                t  = xs;
                xs = xe;
                xe = t;
            end
            if ($urandom_range(3) == 0)
            begin
                t  = ys;
                ys = ye;
                ye = t;
            end
        end
        case ($urandom_range(15))
            0:       lim = 8'd0;
            1:       lim = 8'd255;
            default: lim = 8'($urandom_range(48, 1));
        endcase
        write_reg(REG_X_START, xs);
        write_reg(REG_Y_START, ys);
        write_reg(REG_X_END, xe);
        write_reg(REG_Y_END, ye);
        write_reg(REG_WIDTH, {19'($urandom), random_dim()});
        write_reg(REG_HEIGHT, {19'($urandom), random_dim()});
        write_reg(REG_LIMIT, {24'($urandom), lim});
    endtask

    task automatic test_reset_window();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd768, 12'd512);
        // c = -2 sits exactly on the escape radius and never leaves it
        send_pixel(12'd0, 12'd512);
        wait_drained();
    endtask

    task automatic test_limits_and_dims();
        write_reg(REG_LIMIT, 32'd0);
        send_pixel(12'd512, 12'd512);
        wait_drained();
        write_reg(REG_LIMIT, 32'hFFFF_FF01);
        send_pixel(12'd512, 12'd512);
        wait_drained();
        write_reg(REG_LIMIT, 32'd17);
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        wait_drained();
        // oversized dimensions fall back to the largest image
        write_reg(REG_WIDTH, 32'h0000_1FFF);
        write_reg(REG_HEIGHT, 32'd4097);
        send_pixel(12'd4095, 12'd2048);
        send_pixel(12'd2730, 12'd2048);
        wait_drained();
    endtask

    task automatic test_window_extremes();
        write_reg(REG_X_START, 32'h8000_0000);
        write_reg(REG_X_END, 32'h7FFF_FFFF);
        write_reg(REG_Y_START, 32'h7FFF_FFFF);
        write_reg(REG_Y_END, 32'h8000_0000);
        write_reg(REG_WIDTH, 32'd1);
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_LIMIT, 32'd255);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        wait_drained();
        write_reg(REG_X_START, 32'h1000_0000);
        write_reg(REG_X_END, 32'hE000_0000);
        write_reg(REG_Y_START, 32'h1800_0000);
        write_reg(REG_Y_END, 32'hE800_0000);
        write_reg(REG_WIDTH, 32'd1024);
        write_reg(REG_HEIGHT, 32'd1024);
        send_pixel(12'd256, 12'd512);
        send_pixel(12'd1024, 12'd512);
        send_pixel(12'd100, 12'd900);
        wait_drained();
        // no register behind this index, the window must stay as it was
        write_reg(REG_UNUSED, 32'h0000_0001);
        send_pixel(12'd256, 12'd512);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent         = 0;
        while (sent < n_items)
        begin
            wait_drained();
            load_random_window();
            repeat ($urandom_range(24, 8))
            begin
                send_pixel(random_pos(window.width), random_pos(window.height));
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_left    = HOLD_CYCLES;
        repeat (6)
            send_pixel(random_pos(window.width), random_pos(window.height));
        wait_drained();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        pixel_column = '0;
        pixel_row    = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_X_START;
        cfg_data     = '0;
        src_idle_pct = 17;
        snk_idle_pct = 69;
        hold_left    = 0;
        quiet_cycles = 0;
        n_pixels     = 0;
        n_checked    = 0;
        n_cfg_writes = 0;
        n_errors     = 0;
        window       = '{X_START_RST, Y_START_RST, X_END_RST, Y_END_RST,
                         DIM_RST, DIM_RST, LIMIT_RST};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_limits_and_dims();
        test_window_extremes();
        test_random_traffic(17, 69, 160);
        test_random_traffic(69, 17, 160);
        test_random_traffic(0, 0, 160);
        test_output_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_counts.size() != 0)
        begin
            $display("%0t: %0d escape counts never arrived", $time, pending_counts.size());
            n_errors += pending_counts.size();
        end
        $display("%0d pixels sent, %0d escape counts checked, %0d register writes",
                 n_pixels, n_checked, n_cfg_writes);
        $display("windows: reset, saturated, reversed and random; zero and oversized sizes");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("%0t: no beat on any channel for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/mandel_pkg.sv
src/mandel_div.sv
src/mandelbrot_escape_time_pixel.sv
bench/tb_top.sv
